@@ design/sorted_store_with_search_top_assert.svh @@
// assertion macros shared by the checker
`ifndef SORTED_STORE_WITH_SEARCH_TOP_ASSERT_SVH
`define SORTED_STORE_WITH_SEARCH_TOP_ASSERT_SVH

// same-cycle implication, quiet while reset is held
`define SSS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted store check failed");

// next-cycle implication, quiet while reset is held
`define SSS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted store check failed");

`endif

@@ design/sss_pkg.sv @@
package sss_pkg;

  // operation codes
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;

  // status codes
  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_FOUND    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  localparam int VAL_W   = 16;
  localparam int POS_W   = 6;
  localparam int COUNT_W = 7;

  typedef logic [VAL_W-1:0] val_t;

  // compare flags one cell reports against the current key
  typedef struct packed {
    logic gt;
    logic lt;
    logic le;
  } cmp_t;

endpackage

@@ design/sss_if.sv @@
interface sss_in_if import sss_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] op;
  val_t       value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

interface sss_out_if import sss_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [POS_W-1:0]   first_pos;
  logic [POS_W-1:0]   last_pos;
  logic [COUNT_W-1:0] stored_count;

  modport source (output valid, output status, output first_pos, output last_pos,
                  output stored_count, input ready);
  modport sink   (input valid, input status, input first_pos, input last_pos,
                  input stored_count, output ready);
endinterface

@@ design/sss_cell.sv @@
module sss_cell import sss_pkg::*; (
  input  logic clk,
  input  logic ins_en,
  input  logic occ,
  input  logic gt_prev,
  input  val_t left_val,
  input  val_t key,
  output val_t val,
  output cmp_t cmp
);

  val_t val_r;
  val_t val_nxt;

  assign val = val_r;

  always_comb begin
    cmp.gt = occ && (val_r > key);
    cmp.lt = occ && (val_r < key);
    cmp.le = occ && (val_r <= key);
  end

  // left neighbor larger: shift right; first larger or free slot: take key
  always_comb begin
    val_nxt = val_r;
    if (ins_en) begin
      if (gt_prev) begin
        val_nxt = left_val;
      end else if (cmp.gt || !occ) begin
        val_nxt = key;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

@@ design/sss_encode.sv @@
module sss_encode #(
  parameter int DEPTH = 64,
  parameter int EW    = 7
) (
  input  logic [DEPTH-1:0] lt,
  input  logic [DEPTH-1:0] le,
  output logic             found,
  output logic [EW-1:0]    first,
  output logic [EW-1:0]    last
);

  logic [DEPTH:0] lt_ext;
  logic [DEPTH:0] le_ext;

  assign lt_ext = {1'b0, lt};
  assign le_ext = {1'b0, le};
  assign found  = |(le & ~lt);

  // flags form a prefix of ones, so each vector has one edge at most
  always_comb begin
    first = '0;
    last  = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (lt_ext[i] && !lt_ext[i+1]) begin
        first = first | EW'(i + 1);
      end
      if (le_ext[i] && !le_ext[i+1]) begin
        last = last | EW'(i);
      end
    end
  end

endmodule

@@ design/sorted_store_with_search_top.sv @@
// Sorted store with search: keeps up to DEPTH unsigned Q10.6 values in
// ascending order in a row of compare-and-shift cells. op clear empties the
// store, op insert places the value after every stored value less than or
// equal to it (status full and the value dropped when the store holds DEPTH
// entries), op search reports found with the first and last sorted positions
// of the run equal to the key, or not found. Each transaction gives exactly
// one result transaction carrying the entry count after the item. One item
// is in work at a time: in the accept cycle every cell compares its entry
// with the key in parallel and an insert shifts the larger entries one cell
// right; then the registered compare flags are encoded into positions and
// loaded into the output register once it is free or being drained. The
// next item is taken while a result still waits there.
// Positions are reported modulo 64 and the count modulo 128. No clearing
// pass is needed after reset.
module sorted_store_with_search_top import sss_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  sss_in_if.sink        in_ch,
  sss_out_if.source     out_ch
);

  // count width holds DEPTH itself; encode width also covers the 7-bit field
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = (CW > COUNT_W) ? CW : COUNT_W;

  // control state
  logic          busy_r, busy_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_r, out_valid_nxt;

  // item held between accept and result
  logic [1:0]       op_r;
  logic             full_r;
  logic [CW-1:0]    snap_r;
  logic [DEPTH-1:0] lt_r;
  logic [DEPTH-1:0] le_r;

  // output register payload
  logic [1:0]         status_r;
  logic [POS_W-1:0]   first_r;
  logic [POS_W-1:0]   last_r;
  logic [COUNT_W-1:0] cnt_out_r;

  logic accept;
  logic full;
  logic ins_en;
  logic load_out;

  // chain wiring
  val_t             cell_val [DEPTH];
  cmp_t             cell_cmp [DEPTH];
  logic [DEPTH-1:0] occ;
  logic [DEPTH-1:0] lt_v;
  logic [DEPTH-1:0] le_v;

  // encoder outputs
  logic          found;
  logic [EW-1:0] enc_first;
  logic [EW-1:0] enc_last;
  logic [1:0]    status_nxt;

  assign in_ch.ready = !busy_r;
  assign accept      = in_ch.valid && in_ch.ready;
  assign full        = (count_r == CW'(DEPTH));
  assign ins_en      = accept && (in_ch.op == OP_INSERT) && !full;

  // the cell row: cell i is occupied below the entry count
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic gt_prev;
    val_t left_val;

    if (i == 0) begin : g_head
      assign gt_prev  = 1'b0;
      assign left_val = in_ch.value;
    end else begin : g_body
      assign gt_prev  = cell_cmp[i-1].gt;
      assign left_val = cell_val[i-1];
    end

    assign occ[i]  = (CW'(i) < count_r);
    assign lt_v[i] = cell_cmp[i].lt;
    assign le_v[i] = cell_cmp[i].le;

    sss_cell u_cell (
      .clk      (clk),
      .ins_en   (ins_en),
      .occ      (occ[i]),
      .gt_prev  (gt_prev),
      .left_val (left_val),
      .key      (in_ch.value),
      .val      (cell_val[i]),
      .cmp      (cell_cmp[i])
    );
  end

  // entry count follows the accepted transaction
  always_comb begin
    count_nxt = count_r;
    if (accept) begin
      unique case (in_ch.op)
        OP_CLEAR:  count_nxt = '0;
        OP_INSERT: if (!full) count_nxt = count_r + CW'(1);
        default:   count_nxt = count_r;
      endcase
    end
  end

  // after acceptance: turn the captured flags into positions
  sss_encode #(
    .DEPTH (DEPTH),
    .EW    (EW)
  ) u_encode (
    .lt    (lt_r),
    .le    (le_r),
    .found (found),
    .first (enc_first),
    .last  (enc_last)
  );

  always_comb begin
    unique case (op_r)
      OP_INSERT: status_nxt = full_r ? ST_FULL : ST_DONE;
      OP_SEARCH: status_nxt = found ? ST_FOUND : ST_NOTFOUND;
      default:   status_nxt = ST_DONE;
    endcase
  end

  // result moves out when the output register is free or being drained
  assign load_out = busy_r && (!out_valid_r || out_ch.ready);

  always_comb begin
    busy_nxt = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end else if (load_out) begin
      busy_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // capture the item and the compare flags of the cells
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_ch.op;
      full_r <= full;
      snap_r <= count_nxt;
      lt_r   <= lt_v;
      le_r   <= le_v;
    end
  end

  // positions are zero unless the key was found
  always_ff @(posedge clk) begin
    if (load_out) begin
      status_r  <= status_nxt;
      first_r   <= (status_nxt == ST_FOUND) ? enc_first[POS_W-1:0] : '0;
      last_r    <= (status_nxt == ST_FOUND) ? enc_last[POS_W-1:0] : '0;
      cnt_out_r <= COUNT_W'(snap_r);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = status_r;
  assign out_ch.first_pos    = first_r;
  assign out_ch.last_pos     = last_r;
  assign out_ch.stored_count = cnt_out_r;

endmodule

@@ design/sss_checker.sv @@
`include "sorted_store_with_search_top_assert.svh"

module sss_checker import sss_pkg::*; #(
  parameter int DEPTH = 64
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         out_status,
  input logic [POS_W-1:0]   out_first_pos,
  input logic [POS_W-1:0]   out_last_pos,
  input logic [COUNT_W-1:0] out_stored_count
);

  localparam logic [COUNT_W-1:0] DEPTH_MOD = COUNT_W'(DEPTH);

  // a stalled result keeps its payload
  `SSS_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_stored_count))

  // a full report means the store holds DEPTH entries
  `SSS_ASSERT_NOW(a_full_count, clk, rst_n, out_valid && (out_status == ST_FULL), out_stored_count == DEPTH_MOD)

  // positions stay zero unless the key was found
  `SSS_ASSERT_NOW(a_pos_zero, clk, rst_n, out_valid && (out_status != ST_FOUND), (out_first_pos == '0) && (out_last_pos == '0))

  // an accepted item blocks further input until its result moves to the output register
  `SSS_ASSERT_NXT(a_one_in_work, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

bind sorted_store_with_search_top sss_checker #(.DEPTH(DEPTH)) u_sss_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_status       (out_ch.status),
  .out_first_pos    (out_ch.first_pos),
  .out_last_pos     (out_ch.last_pos),
  .out_stored_count (out_ch.stored_count)
);

@@ tb/tb_sorted_store_with_search_top.sv @@
module tb_sorted_store_with_search_top;
  import sss_pkg::*;

  localparam int STORE_DEPTH  = 64;
  localparam int HOLD_CYCLES  = 300;
  localparam int LIMIT_CYCLES = 400000;
  localparam int SETTLE       = 10;

  // op code 3 is not assigned by the package; the block must leave the store alone
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]         status;
    logic [POS_W-1:0]   first_pos;
    logic [POS_W-1:0]   last_pos;
    logic [COUNT_W-1:0] stored_count;
  } sss_result_t;

  logic clk;
  logic rst_n;

  sss_in_if  in_ch ();
  sss_out_if out_ch ();

  sorted_store_with_search_top #(.DEPTH(STORE_DEPTH)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // shadow copy of the sorted store, updated at every accepted input transaction
  val_t        shadow_values [0:STORE_DEPTH-1];
  int          shadow_count;
  // predicted result transactions, oldest first
  sss_result_t awaited_results [$];

  int errors;
  int cycle_count;
  // idle chances in percent for the sender and the receiver
  int src_idle;
  int sink_idle;
  // the receiver starts a long hold-off whenever hold_asked moves past hold_taken
  int hold_asked;
  int hold_taken;
  int hold_left;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // runaway guard: no correct run comes anywhere near this
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("** sorted_store_with_search_top: FAILED **");
      $finish;
    end
  end

  // predicts one result from one accepted item and updates the shadow store;
  // an insert goes after every equal entry, a search walks to the first entry
  // not below the key and then along the run of equal entries
  function automatic sss_result_t sort_and_search(logic [1:0] op, val_t value);
    sss_result_t r;
    int          i;
    r = '0;
    r.status = ST_DONE;
    case (op)
      OP_CLEAR: begin
        shadow_count = 0;
      end
      OP_INSERT: begin
        if (shadow_count >= STORE_DEPTH) begin
          // full store: value dropped, nothing moves
          r.status = ST_FULL;
        end else begin
          i = shadow_count;
          while (i > 0 && shadow_values[i-1] > value) begin
            shadow_values[i] = shadow_values[i-1];
            i--;
          end
          shadow_values[i] = value;
          shadow_count++;
        end
      end
      OP_SEARCH: begin
        i = 0;
        while (i < shadow_count && shadow_values[i] < value) i++;
        if (i < shadow_count && shadow_values[i] == value) begin
          r.status    = ST_FOUND;
          r.first_pos = i[POS_W-1:0];
          while (i + 1 < shadow_count && shadow_values[i+1] == value) i++;
          r.last_pos  = i[POS_W-1:0];
        end else begin
          // includes the empty store
          r.status = ST_NOTFOUND;
        end
      end
      default: begin
        // unused op code: store untouched, status done
      end
    endcase
    r.stored_count = shadow_count[COUNT_W-1:0];
    return r;
  endfunction

  function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
    end
  endfunction

  // monitor: both handshakes are sampled at the rising edge, before any update
  // of that edge lands, so the view is the same whatever order processes run in
  always @(posedge clk) begin : monitor
    sss_result_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_results.size() == 0) begin
          errors++;
          $display("%0t: result transaction with nothing expected, status %0d count %0d",
                   $time, out_ch.status, out_ch.stored_count);
        end else begin
          want = awaited_results.pop_front();
          check_field("status",       8'(want.status),       8'(out_ch.status));
          check_field("first_pos",    8'(want.first_pos),    8'(out_ch.first_pos));
          check_field("last_pos",     8'(want.last_pos),     8'(out_ch.last_pos));
          check_field("stored_count", 8'(want.stored_count), 8'(out_ch.stored_count));
        end
      end
      if (in_ch.valid && in_ch.ready)
        awaited_results.push_back(sort_and_search(in_ch.op, in_ch.value));
    end
  end

  // receiver: random stalls, or a long hold-off when one is asked for
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left = 0;
    end else if (hold_taken != hold_asked) begin
      hold_taken = hold_asked;
      hold_left  = HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= sink_idle);
    end
  end

  // offers one input transaction and returns at the edge that accepts it;
  // valid is left high so back-to-back items need no extra edge
  task automatic send_item(input logic [1:0] op, input val_t value);
    while ($urandom_range(99) < src_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op    <= op;
    in_ch.value <= value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // sender goes quiet until every predicted result has come back
  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  // mix of corner codes, a narrow band that makes duplicates, and full-range codes
  function automatic val_t pick_value();
    case ($urandom_range(3))
      0: begin
        case ($urandom_range(4))
          0:       return 16'h0000;
          1:       return 16'hFFFF;
          2:       return 16'h8000;
          3:       return 16'h7FFF;
          default: return 16'h0001;
        endcase
      end
      1:       return val_t'($urandom_range(31));
      default: return val_t'($urandom);
    endcase
  endfunction

  // search key: usually something already stored so runs get found
  function automatic val_t pick_key();
    if (shadow_count > 0 && $urandom_range(2) != 0)
      return shadow_values[$urandom_range(shadow_count - 1)];
    return pick_value();
  endfunction

  // extremes, equal runs at the top end and in the middle, empty store,
  // unused op code, clear followed by search
  task automatic test_directed();
    send_item(OP_SEARCH, 16'h0000);
    send_item(OP_UNUSED, 16'hFFFF);
    send_item(OP_INSERT, 16'hFFFF);
    send_item(OP_INSERT, 16'h0000);
    send_item(OP_INSERT, 16'h8000);
    send_item(OP_INSERT, 16'h8000);
    send_item(OP_INSERT, 16'h7FFF);
    send_item(OP_INSERT, 16'h8000);
    send_item(OP_INSERT, 16'h8001);
    send_item(OP_INSERT, 16'hFFFF);
    send_item(OP_SEARCH, 16'h0000);
    send_item(OP_SEARCH, 16'hFFFF);
    send_item(OP_SEARCH, 16'h8000);
    send_item(OP_SEARCH, 16'h4000);
    send_item(OP_SEARCH, 16'hFFFE);
    send_item(OP_UNUSED, 16'h5555);
    send_item(OP_CLEAR,  16'hAAAA);
    send_item(OP_SEARCH, 16'h8000);
    send_item(OP_INSERT, 16'hAAAA);
    send_item(OP_SEARCH, 16'hAAAA);
    send_item(OP_CLEAR,  16'h5555);
    wait_drain();
  endtask

  // fill to the last entry, then overflow inserts are dropped with full status
  task automatic test_full_store();
    int k;
    send_item(OP_CLEAR, pick_value());
    for (k = 0; k < STORE_DEPTH; k++) send_item(OP_INSERT, pick_value());
    for (k = 0; k < 3; k++) send_item(OP_INSERT, pick_value());
    send_item(OP_SEARCH, 16'h0000);
    send_item(OP_SEARCH, 16'hFFFF);
    for (k = 0; k < 6; k++) send_item(OP_SEARCH, pick_key());
    send_item(OP_UNUSED, pick_value());
    send_item(OP_INSERT, 16'h1234);
    wait_drain();
  endtask

  // receiver holds off for a long stretch while the sender keeps offering,
  // so the output register and the item in work back up into the input
  task automatic test_backpressure();
    int k;
    hold_asked++;
    for (k = 0; k < 24; k++) begin
      if (k % 3 == 2) send_item(OP_SEARCH, pick_key());
      else            send_item(OP_INSERT, pick_value());
    end
    wait_drain();
  endtask

  // mostly inserts and searches; clears are rare so the store often fills up
  task automatic test_random(input int n_items);
    int k;
    int pick;
    for (k = 0; k < n_items; k++) begin
      pick = $urandom_range(99);
      if (pick < 1)       send_item(OP_CLEAR, pick_value());
      else if (pick < 4)  send_item(OP_UNUSED, pick_value());
      else if (pick < 58) send_item(OP_INSERT, pick_value());
      else                send_item(OP_SEARCH, pick_key());
    end
    wait_drain();
  endtask

  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.op     = OP_CLEAR;
    in_ch.value  = '0;
    out_ch.ready = 1'b0;
    errors       = 0;
    cycle_count  = 0;
    shadow_count = 0;
    hold_asked   = 0;
    hold_taken   = 0;
    src_idle     = 26;
    sink_idle    = 83;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // sender idles now and then, receiver mostly stalls
    test_directed();
    test_full_store();
    test_backpressure();
    test_random(430);

    // the other way round
    src_idle  = 83;
    sink_idle = 26;
    test_full_store();
    test_random(430);

    // no idling on either side
    src_idle  = 0;
    sink_idle = 0;
    test_backpressure();
    test_random(430);

    // let any stray result show up before the verdict
    wait_drain();
    repeat (SETTLE) @(posedge clk);
    if (awaited_results.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, awaited_results.size());
    end
    if (errors == 0) begin
      $display("** sorted_store_with_search_top: PASSED **");
    end else begin
      $display("** sorted_store_with_search_top: FAILED **");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/sss_pkg.sv
design/sss_if.sv
design/sss_cell.sv
design/sss_encode.sv
design/sorted_store_with_search_top.sv
design/sss_checker.sv
tb/tb_sorted_store_with_search_top.sv
